### rtl/rdsc_pkg.sv
package rdsc_pkg;

   localparam int VALUE_W = 32;
   localparam int RADIX_W = 5;
   localparam int CHAR_W  = 8;
   localparam int DIGIT_W = 4;

   localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd16;
   localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

   localparam logic [CHAR_W-1:0]  CH_ZERO   = 8'd48;
   localparam logic [CHAR_W-1:0]  CH_ALPHA  = 8'd55;
   localparam logic [CHAR_W-1:0]  CH_MINUS  = 8'd45;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_STEP,
      ST_EMIT_SIGN,
      ST_EMIT_ZERO,
      ST_READ,
      ST_SHOW
   } rdsc_state_type;

   typedef enum logic [1:0] {
      SEL_MINUS,
      SEL_ZERO,
      SEL_DIGIT
   } rdsc_char_sel_type;

   typedef struct packed {
      logic              csr_wr;
      logic              load;
      logic              div_start;
      logic              div_step;
      logic              rd_first;
      logic              rd_next;
      logic              out_load;
      rdsc_char_sel_type out_sel;
   } rdsc_cmd_type;

   typedef struct packed {
      logic q_zero;
      logic cnt_full;
      logic cnt_zero;
      logic bidx_zero;
      logic idx_zero;
      logic neg;
      logic out_free;
   } rdsc_status_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] ext;
      ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
      return (d <= DIGIT_MAX) ? (CH_ZERO + ext) : (CH_ALPHA + ext);
   endfunction

endpackage

### rtl/radix_digit_string_converter.sv
// channel  direction  handshake           payload
// req      in         req_valid/req_stall req_value[31:0] signed
// rsp      out        rsp_valid/rsp_stall rsp_ascii_char[7:0], rsp_last
// csr      in         csr_valid/csr_ready csr_data[4:0] (radix)
//
// one value per conversion: an accept state, then per digit a setup state plus
// a division step for each byte of the running quotient up to its highest nonzero byte
// (byte-wide long division), a final check, a sign beat when negative,
// a digit-store read, then a beat for each digit
// reset is synchronous and sets the radix to 16; digit store is not cleared
// rsp_stall holds the output register and pauses emission; req_stall is low
// only while idle, which is also when csr writes are taken
module radix_digit_string_converter #(
   parameter int MAX_DIGITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [rdsc_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic        [rdsc_pkg::CHAR_W-1:0]   rsp_ascii_char,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic        [rdsc_pkg::RADIX_W-1:0]  csr_data
);

   rdsc_pkg::rdsc_cmd_type    cmd;
   rdsc_pkg::rdsc_status_type status;

   rdsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rdsc_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_value      (req_value),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last       (rsp_last),
      .rsp_stall      (rsp_stall)
   );

endmodule

### rtl/rdsc_datapath.sv
module rdsc_datapath #(
   parameter int MAX_DIGITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  rdsc_pkg::rdsc_cmd_type               cmd,
   output rdsc_pkg::rdsc_status_type            status,
   input  logic signed [rdsc_pkg::VALUE_W-1:0]  req_value,
   input  logic        [rdsc_pkg::RADIX_W-1:0]  csr_data,
   output logic                                 rsp_valid,
   output logic        [rdsc_pkg::CHAR_W-1:0]   rsp_ascii_char,
   output logic                                 rsp_last,
   input  logic                                 rsp_stall
);

   localparam int ADDR_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);

   logic [rdsc_pkg::RADIX_W-1:0] radix_ff, radix_in;
   logic [rdsc_pkg::RADIX_W-1:0] base_ff, base_in;
   logic [rdsc_pkg::VALUE_W-1:0] q_ff, q_in;
   logic                         neg_ff, neg_in;
   logic [rdsc_pkg::DIGIT_W-1:0] rem_ff, rem_in;
   logic [1:0]                   bidx_ff, bidx_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [ADDR_W-1:0]            idx_ff, idx_in;
   logic [rdsc_pkg::DIGIT_W-1:0] rd_data_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rdsc_pkg::CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic [rdsc_pkg::DIGIT_W-1:0] digit_mem [MAX_DIGITS];

   logic [rdsc_pkg::RADIX_W-1:0] eff_base;
   logic [rdsc_pkg::VALUE_W-1:0] mag;
   logic [7:0]                   cur_byte, quot_byte;
   logic [4:0]                   part_rem;
   logic [rdsc_pkg::DIGIT_W-1:0] step_rem;
   logic [rdsc_pkg::VALUE_W-1:0] q_step;
   logic [1:0]                   top_byte;
   logic [CNT_W-1:0]             cnt_dec;
   logic [ADDR_W-1:0]            rd_addr;
   logic                         rd_en;
   logic                         digit_done;

   always_comb begin
      if (radix_ff < rdsc_pkg::RADIX_MIN) begin
         eff_base = rdsc_pkg::RADIX_MIN;
      end else if (radix_ff > rdsc_pkg::RADIX_MAX) begin
         eff_base = rdsc_pkg::RADIX_MAX;
      end else begin
         eff_base = radix_ff;
      end
   end

   assign mag = req_value[rdsc_pkg::VALUE_W-1] ? (~req_value + 32'd1) : req_value;

   // one byte of restoring long division per cycle; remainder stays below base
   always_comb begin
      cur_byte = q_ff[{bidx_ff, 3'b000} +: 8];
      part_rem = {1'b0, rem_ff};
      quot_byte = '0;
      for (int i = 7; i >= 0; i--) begin
         part_rem = {part_rem[3:0], cur_byte[i]};
         if (part_rem >= base_ff) begin
            part_rem = part_rem - base_ff;
            quot_byte[i] = 1'b1;
         end
      end
      step_rem = part_rem[rdsc_pkg::DIGIT_W-1:0];
      q_step = q_ff;
      q_step[{bidx_ff, 3'b000} +: 8] = quot_byte;
   end

   // skip leading zero bytes of the running quotient
   always_comb begin
      if (q_ff[31:24] != 8'd0) begin
         top_byte = 2'd3;
      end else if (q_ff[23:16] != 8'd0) begin
         top_byte = 2'd2;
      end else if (q_ff[15:8] != 8'd0) begin
         top_byte = 2'd1;
      end else begin
         top_byte = 2'd0;
      end
   end

   assign digit_done = cmd.div_step && (bidx_ff == 2'd0);
   assign cnt_dec    = cnt_ff - CNT_W'(1);
   assign rd_en      = cmd.rd_first || cmd.rd_next;
   assign rd_addr    = cmd.rd_first ? cnt_dec[ADDR_W-1:0] : (idx_ff - ADDR_W'(1));

   always_comb begin
      radix_in = radix_ff;
      base_in  = base_ff;
      q_in     = q_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      bidx_in  = bidx_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      if (cmd.csr_wr) begin
         radix_in = csr_data;
      end
      if (cmd.load) begin
         q_in    = mag;
         neg_in  = req_value[rdsc_pkg::VALUE_W-1];
         base_in = eff_base;
         cnt_in  = '0;
      end
      if (cmd.div_start) begin
         bidx_in = top_byte;
         rem_in  = '0;
      end
      if (cmd.div_step) begin
         q_in    = q_step;
         rem_in  = step_rem;
         bidx_in = bidx_ff - 2'd1;
         if (digit_done) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
      if (rd_en) begin
         idx_in = rd_addr;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         case (cmd.out_sel)
            rdsc_pkg::SEL_MINUS: begin
               rsp_char_in = rdsc_pkg::CH_MINUS;
               rsp_last_in = (cnt_ff == '0);
            end
            rdsc_pkg::SEL_ZERO: begin
               rsp_char_in = rdsc_pkg::CH_ZERO;
               rsp_last_in = 1'b1;
            end
            rdsc_pkg::SEL_DIGIT: begin
               rsp_char_in = rdsc_pkg::digit_char(rd_data_ff);
               rsp_last_in = (idx_ff == '0);
            end
            default: begin
               rsp_char_in = rdsc_pkg::CH_ZERO;
               rsp_last_in = 1'b1;
            end
         endcase
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff     <= rdsc_pkg::RADIX_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         q_ff         <= '0;
      end else begin
         radix_ff     <= radix_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         q_ff         <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      bidx_ff     <= bidx_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (digit_done) begin
         digit_mem[cnt_ff[ADDR_W-1:0]] <= step_rem;
      end
      if (rd_en) begin
         rd_data_ff <= digit_mem[rd_addr];
      end
   end

   assign status.q_zero    = (q_ff == '0);
   assign status.cnt_full  = (cnt_ff == CNT_W'(MAX_DIGITS));
   assign status.cnt_zero  = (cnt_ff == '0);
   assign status.bidx_zero = (bidx_ff == 2'd0);
   assign status.idx_zero  = (idx_ff == '0);
   assign status.neg       = neg_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

### rtl/rdsc_ctrl.sv
module rdsc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  rdsc_pkg::rdsc_status_type status,
   output rdsc_pkg::rdsc_cmd_type    cmd
);

   rdsc_pkg::rdsc_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rdsc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = rdsc_pkg::ST_DIV_START;
            end
         end
         rdsc_pkg::ST_DIV_START: begin
            if (!status.q_zero && !status.cnt_full) begin
               state_in = rdsc_pkg::ST_DIV_STEP;
            end else if (status.neg) begin
               state_in = rdsc_pkg::ST_EMIT_SIGN;
            end else if (status.cnt_zero) begin
               state_in = rdsc_pkg::ST_EMIT_ZERO;
            end else begin
               state_in = rdsc_pkg::ST_READ;
            end
         end
         rdsc_pkg::ST_DIV_STEP: begin
            if (status.bidx_zero) begin
               state_in = rdsc_pkg::ST_DIV_START;
            end
         end
         rdsc_pkg::ST_EMIT_SIGN: begin
            if (status.out_free) begin
               state_in = status.cnt_zero ? rdsc_pkg::ST_EMIT_ZERO : rdsc_pkg::ST_READ;
            end
         end
         rdsc_pkg::ST_EMIT_ZERO: begin
            if (status.out_free) begin
               state_in = rdsc_pkg::ST_IDLE;
            end
         end
         rdsc_pkg::ST_READ: begin
            state_in = rdsc_pkg::ST_SHOW;
         end
         rdsc_pkg::ST_SHOW: begin
            if (status.out_free && status.idx_zero) begin
               state_in = rdsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rdsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.out_sel   = rdsc_pkg::SEL_DIGIT;
      req_stall     = 1'b1;
      csr_ready     = 1'b0;
      case (state_ff)
         rdsc_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            csr_ready  = 1'b1;
            cmd.csr_wr = csr_valid;
            cmd.load   = req_valid;
         end
         rdsc_pkg::ST_DIV_START: begin
            cmd.div_start = 1'b1;
         end
         rdsc_pkg::ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
         end
         rdsc_pkg::ST_EMIT_SIGN: begin
            cmd.out_load = status.out_free;
            cmd.out_sel  = rdsc_pkg::SEL_MINUS;
         end
         rdsc_pkg::ST_EMIT_ZERO: begin
            cmd.out_load = status.out_free;
            cmd.out_sel  = rdsc_pkg::SEL_ZERO;
         end
         rdsc_pkg::ST_READ: begin
            cmd.rd_first = 1'b1;
         end
         rdsc_pkg::ST_SHOW: begin
            // prefetch the next digit while this one goes out
            cmd.out_load = status.out_free;
            cmd.rd_next  = status.out_free && !status.idx_zero;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rdsc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
